// ===== rtl/srsm_pkg.sv =====
package srsm_pkg;

    // Screen and viewport geometry
    localparam int SCREEN_WIDTH  = 320;
    localparam int SCREEN_HEIGHT = 240;
    localparam int VIEW_TOP      = 22;
    localparam int VIEW_HEIGHT   = 188;
    localparam int MAX_SIDE      = 4096;

    // Field widths
    localparam int IMG_W      = 13;
    localparam int ROT_W      = 2;
    localparam int ZOOM_W     = 2;
    localparam int PAN_W      = 14;
    localparam int COL_W      = 9;
    localparam int ROW_W      = 8;
    localparam int SRC_W      = 12;
    localparam int INDEX_W    = 24;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 14;

    // Derived datapath widths
    localparam int FRAC_W    = 16;
    localparam int SCR_MAX   = SCREEN_WIDTH > SCREEN_HEIGHT ? SCREEN_WIDTH : SCREEN_HEIGHT;
    localparam int FIT_W     = $clog2(SCR_MAX + 1) + FRAC_W;
    localparam int FIX_W     = FRAC_W + 2;
    localparam int SCALE_W   = FIT_W > FIX_W ? FIT_W : FIX_W;
    localparam int TGT_FIX_W = IMG_W + 1;
    localparam int TGT_FIT_W = $clog2(SCR_MAX + 2);
    localparam int TGT_W     = TGT_FIX_W > TGT_FIT_W ? TGT_FIX_W : TGT_FIT_W;
    localparam int POS_W     = TGT_W + 4;
    localparam int PROD_W    = IMG_W + SCALE_W;
    localparam int NUM_W     = TGT_W + FRAC_W;
    localparam int CNT_W     = $clog2(SCALE_W);

    // Fixed 9.16 scale factors
    localparam logic [SCALE_W-1:0] SCALE_100 = SCALE_W'(65536);
    localparam logic [SCALE_W-1:0] SCALE_150 = SCALE_W'(98304);
    localparam logic [SCALE_W-1:0] SCALE_200 = SCALE_W'(131072);
    localparam logic [SCALE_W-1:0] SCALE_MIN = SCALE_W'(1);
    localparam logic [PROD_W:0]    ROUND_UP  = (PROD_W + 1)'(65535);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_IMAGE_WIDTH,
        CFG_IMAGE_HEIGHT,
        CFG_ROTATION_STEP,
        CFG_ZOOM_SELECT,
        CFG_OVERLAY_SHOWN,
        CFG_PAN_HORIZONTAL,
        CFG_PAN_VERTICAL
    } cfg_index_t;

    typedef enum logic [ROT_W-1:0] {ROT_0, ROT_90, ROT_180, ROT_270} rot_t;

    typedef enum logic [ZOOM_W-1:0] {ZOOM_FIT, ZOOM_100, ZOOM_150, ZOOM_200} zoom_t;

    typedef enum logic [3:0] {
        ST_START,
        ST_DIV,
        ST_SCALE,
        ST_MULW,
        ST_MULH,
        ST_SPAN,
        ST_OFFS,
        ST_PLACE,
        ST_READY
    } setup_state_t;

    typedef struct packed {
        logic [COL_W-1:0] screen_col;
        logic [ROW_W-1:0] screen_row;
    } pix_in_t;

    typedef struct packed {
        logic               covered;
        logic [SRC_W-1:0]   src_col;
        logic [SRC_W-1:0]   src_row;
        logic [INDEX_W-1:0] src_index;
    } pix_out_t;

    // Per-frame placement, fixed while pixels flow
    typedef struct packed {
        logic                     bad;
        rot_t                     rot;
        logic [IMG_W-1:0]         w;
        logic [IMG_W-1:0]         h;
        logic [IMG_W-1:0]         rw;
        logic [IMG_W-1:0]         rh;
        logic [TGT_W-1:0]         tw;
        logic [TGT_W-1:0]         th;
        logic signed [POS_W-1:0]  vy;
        logic signed [POS_W-1:0]  vend;
        logic signed [POS_W-1:0]  left;
        logic signed [POS_W-1:0]  top;
        logic [SCALE_W-1:0]       scale;
    } frame_t;

endpackage

// ===== rtl/srsm_stream_if.sv =====
interface srsm_stream_if #(
    parameter type data_t = logic
) ();
    logic  valid;
    logic  ready;
    data_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/srsm_setup.sv =====
module srsm_setup (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [srsm_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [srsm_pkg::CFG_DATA_W-1:0]  cfg_data,
    output srsm_pkg::frame_t                 frame,
    output logic                             ready
);

    localparam int IMG_W   = srsm_pkg::IMG_W;
    localparam int SCALE_W = srsm_pkg::SCALE_W;
    localparam int POS_W   = srsm_pkg::POS_W;
    localparam int TGT_W   = srsm_pkg::TGT_W;
    localparam int PROD_W  = srsm_pkg::PROD_W;
    localparam int FRAC_W  = srsm_pkg::FRAC_W;
    localparam int CNT_W   = srsm_pkg::CNT_W;

    // Configuration registers
    logic [IMG_W-1:0]                   image_width_reg;
    logic [IMG_W-1:0]                   image_height_reg;
    srsm_pkg::rot_t                     rotation_step_reg;
    srsm_pkg::zoom_t                    zoom_select_reg;
    logic                               overlay_shown_reg;
    logic signed [srsm_pkg::PAN_W-1:0]  pan_h_reg;
    logic signed [srsm_pkg::PAN_W-1:0]  pan_v_reg;

    srsm_pkg::setup_state_t state_reg, state_next;
    logic [CNT_W-1:0]       cnt_reg;

    // Working registers
    logic [IMG_W-1:0]        rw_reg, rh_reg;
    logic signed [POS_W-1:0] vy_reg, vh_reg;
    logic                    bad_reg;
    logic [IMG_W-1:0]        hs_rem_reg, vs_rem_reg;
    logic [SCALE_W-1:0]      hs_q_reg, vs_q_reg;
    logic [SCALE_W-1:0]      scale_reg;
    logic [PROD_W-1:0]       prod_reg;
    logic [TGT_W-1:0]        tw_reg, th_reg;
    logic signed [POS_W-1:0] mx_reg, my_reg, halfx_reg, halfy_reg;
    logic signed [POS_W-1:0] left_reg, top_reg, vend_reg;

    // Strobes
    logic do_start, do_div, do_scale, do_mulw, do_mulh, do_span, do_offs, do_place;

    // Config writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            image_width_reg   <= IMG_W'(1);
            image_height_reg  <= IMG_W'(1);
            rotation_step_reg <= srsm_pkg::ROT_0;
            zoom_select_reg   <= srsm_pkg::ZOOM_FIT;
            overlay_shown_reg <= 1'b1;
            pan_h_reg         <= '0;
            pan_v_reg         <= '0;
        end
        else if (cfg_we)
        begin
            unique case (srsm_pkg::cfg_index_t'(cfg_index))
                srsm_pkg::CFG_IMAGE_WIDTH:    image_width_reg   <= cfg_data[IMG_W-1:0];
                srsm_pkg::CFG_IMAGE_HEIGHT:   image_height_reg  <= cfg_data[IMG_W-1:0];
                srsm_pkg::CFG_ROTATION_STEP:
                    rotation_step_reg <= srsm_pkg::rot_t'(cfg_data[srsm_pkg::ROT_W-1:0]);
                srsm_pkg::CFG_ZOOM_SELECT:
                    zoom_select_reg <= srsm_pkg::zoom_t'(cfg_data[srsm_pkg::ZOOM_W-1:0]);
                srsm_pkg::CFG_OVERLAY_SHOWN:  overlay_shown_reg <= cfg_data[0];
                srsm_pkg::CFG_PAN_HORIZONTAL: pan_h_reg <= $signed(cfg_data[srsm_pkg::PAN_W-1:0]);
                srsm_pkg::CFG_PAN_VERTICAL:   pan_v_reg <= $signed(cfg_data[srsm_pkg::PAN_W-1:0]);
                default: ;
            endcase
        end
    end

    // Sequencer state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= srsm_pkg::ST_START;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state; any config write restarts the setup
    always_comb
    begin
        state_next = state_reg;
        if (cfg_we)
        begin
            state_next = srsm_pkg::ST_START;
        end
        else
        begin
            unique case (state_reg)
                srsm_pkg::ST_START: state_next = srsm_pkg::ST_DIV;
                srsm_pkg::ST_DIV:
                    if (cnt_reg == CNT_W'(SCALE_W - 1))
                    begin
                        state_next = srsm_pkg::ST_SCALE;
                    end
                srsm_pkg::ST_SCALE: state_next = srsm_pkg::ST_MULW;
                srsm_pkg::ST_MULW:  state_next = srsm_pkg::ST_MULH;
                srsm_pkg::ST_MULH:  state_next = srsm_pkg::ST_SPAN;
                srsm_pkg::ST_SPAN:  state_next = srsm_pkg::ST_OFFS;
                srsm_pkg::ST_OFFS:  state_next = srsm_pkg::ST_PLACE;
                srsm_pkg::ST_PLACE: state_next = srsm_pkg::ST_READY;
                srsm_pkg::ST_READY: state_next = srsm_pkg::ST_READY;
                default:            state_next = srsm_pkg::ST_START;
            endcase
        end
    end

    // State decode
    always_comb
    begin
        do_start = 1'b0;
        do_div   = 1'b0;
        do_scale = 1'b0;
        do_mulw  = 1'b0;
        do_mulh  = 1'b0;
        do_span  = 1'b0;
        do_offs  = 1'b0;
        do_place = 1'b0;
        ready    = 1'b0;
        unique case (state_reg)
            srsm_pkg::ST_START: do_start = 1'b1;
            srsm_pkg::ST_DIV:   do_div   = 1'b1;
            srsm_pkg::ST_SCALE: do_scale = 1'b1;
            srsm_pkg::ST_MULW:  do_mulw  = 1'b1;
            srsm_pkg::ST_MULH:  do_mulh  = 1'b1;
            srsm_pkg::ST_SPAN:  do_span  = 1'b1;
            srsm_pkg::ST_OFFS:  do_offs  = 1'b1;
            srsm_pkg::ST_PLACE: do_place = 1'b1;
            srsm_pkg::ST_READY: ready    = 1'b1;
            default: ;
        endcase
    end

    // Start values
    logic                    turned;
    logic signed [POS_W-1:0] vh_sel, vy_sel;
    logic                    bad_sel;

    always_comb
    begin
        turned  = (rotation_step_reg == srsm_pkg::ROT_90) ||
                  (rotation_step_reg == srsm_pkg::ROT_270);
        vh_sel  = overlay_shown_reg ? POS_W'(srsm_pkg::VIEW_HEIGHT) : POS_W'(srsm_pkg::SCREEN_HEIGHT);
        vy_sel  = overlay_shown_reg ? POS_W'(srsm_pkg::VIEW_TOP) : '0;
        bad_sel = (image_width_reg == '0) || (image_height_reg == '0) ||
                  (32'(image_width_reg) > 32'(srsm_pkg::MAX_SIDE)) ||
                  (32'(image_height_reg) > 32'(srsm_pkg::MAX_SIDE));
    end

    // Fit-ratio division steps, one quotient bit per cycle for each axis
    logic [IMG_W:0]   hs_t, vs_t;
    logic             hs_ge, vs_ge;
    logic [IMG_W-1:0] hs_rem_next, vs_rem_next;

    always_comb
    begin
        hs_t        = {hs_rem_reg, hs_q_reg[SCALE_W-1]};
        vs_t        = {vs_rem_reg, vs_q_reg[SCALE_W-1]};
        hs_ge       = hs_t >= {1'b0, rw_reg};
        vs_ge       = vs_t >= {1'b0, rh_reg};
        hs_rem_next = hs_ge ? IMG_W'(hs_t - {1'b0, rw_reg}) : hs_t[IMG_W-1:0];
        vs_rem_next = vs_ge ? IMG_W'(vs_t - {1'b0, rh_reg}) : vs_t[IMG_W-1:0];
    end

    // Scale selection
    logic [SCALE_W-1:0] scale_sel;

    always_comb
    begin
        unique case (zoom_select_reg)
            srsm_pkg::ZOOM_100: scale_sel = srsm_pkg::SCALE_100;
            srsm_pkg::ZOOM_150: scale_sel = srsm_pkg::SCALE_150;
            srsm_pkg::ZOOM_200: scale_sel = srsm_pkg::SCALE_200;
            default:            scale_sel = (hs_q_reg < vs_q_reg) ? hs_q_reg : vs_q_reg;
        endcase
        if (scale_sel == '0)
        begin
            scale_sel = srsm_pkg::SCALE_MIN;
        end
    end

    // Target size rounded up, at least one
    logic [PROD_W:0]  prod_rnd;
    logic [TGT_W-1:0] tgt_sel;

    always_comb
    begin
        prod_rnd = {1'b0, prod_reg} + srsm_pkg::ROUND_UP;
        tgt_sel  = prod_rnd[FRAC_W +: TGT_W];
        if (tgt_sel == '0)
        begin
            tgt_sel = TGT_W'(1);
        end
    end

    // Overflow and centring; halving truncates toward zero
    logic signed [POS_W-1:0] diffx, diffy, mx_sel, my_sel, halfx_sel, halfy_sel;

    always_comb
    begin
        diffx     = $signed(POS_W'(srsm_pkg::SCREEN_WIDTH)) - $signed(POS_W'(tw_reg));
        diffy     = vh_reg - $signed(POS_W'(th_reg));
        mx_sel    = (diffx < 0) ? ((-diffx) >>> 1) : '0;
        my_sel    = (diffy < 0) ? ((-diffy) >>> 1) : '0;
        halfx_sel = (diffx < 0) ? -mx_sel : (diffx >>> 1);
        halfy_sel = (diffy < 0) ? -my_sel : (diffy >>> 1);
    end

    // Pan clamp to plus or minus half the overflow
    logic signed [POS_W-1:0] panx, pany, cpx, cpy;

    always_comb
    begin
        panx = POS_W'(pan_h_reg);
        pany = POS_W'(pan_v_reg);
        if (panx > mx_reg)
        begin
            cpx = mx_reg;
        end
        else if (panx < -mx_reg)
        begin
            cpx = -mx_reg;
        end
        else
        begin
            cpx = panx;
        end
        if (pany > my_reg)
        begin
            cpy = my_reg;
        end
        else if (pany < -my_reg)
        begin
            cpy = -my_reg;
        end
        else
        begin
            cpy = pany;
        end
    end

    // Setup datapath
    always_ff @(posedge clk)
    begin
        if (do_start)
        begin
            rw_reg     <= turned ? image_height_reg : image_width_reg;
            rh_reg     <= turned ? image_width_reg : image_height_reg;
            vy_reg     <= vy_sel;
            vh_reg     <= vh_sel;
            bad_reg    <= bad_sel;
            hs_rem_reg <= '0;
            vs_rem_reg <= '0;
            hs_q_reg   <= SCALE_W'(srsm_pkg::SCREEN_WIDTH) << FRAC_W;
            vs_q_reg   <= SCALE_W'(vh_sel) << FRAC_W;
            cnt_reg    <= '0;
        end
        if (do_div)
        begin
            hs_rem_reg <= hs_rem_next;
            vs_rem_reg <= vs_rem_next;
            hs_q_reg   <= {hs_q_reg[SCALE_W-2:0], hs_ge};
            vs_q_reg   <= {vs_q_reg[SCALE_W-2:0], vs_ge};
            cnt_reg    <= cnt_reg + CNT_W'(1);
        end
        if (do_scale)
        begin
            scale_reg <= scale_sel;
        end
        if (do_mulw)
        begin
            prod_reg <= PROD_W'(rw_reg) * PROD_W'(scale_reg);
        end
        if (do_mulh)
        begin
            tw_reg   <= tgt_sel;
            prod_reg <= PROD_W'(rh_reg) * PROD_W'(scale_reg);
        end
        if (do_span)
        begin
            th_reg <= tgt_sel;
        end
        if (do_offs)
        begin
            mx_reg    <= mx_sel;
            my_reg    <= my_sel;
            halfx_reg <= halfx_sel;
            halfy_reg <= halfy_sel;
        end
        if (do_place)
        begin
            left_reg <= halfx_reg - cpx;
            top_reg  <= vy_reg + halfy_reg - cpy;
            vend_reg <= vy_reg + vh_reg;
        end
    end

    always_comb
    begin
        frame.bad   = bad_reg;
        frame.rot   = rotation_step_reg;
        frame.w     = image_width_reg;
        frame.h     = image_height_reg;
        frame.rw    = rw_reg;
        frame.rh    = rh_reg;
        frame.tw    = tw_reg;
        frame.th    = th_reg;
        frame.vy    = vy_reg;
        frame.vend  = vend_reg;
        frame.left  = left_reg;
        frame.top   = top_reg;
        frame.scale = scale_reg;
    end

endmodule

// ===== rtl/srsm_div_pipe.sv =====
module srsm_div_pipe #(
    parameter int NUM_W = srsm_pkg::NUM_W,
    parameter int DEN_W = srsm_pkg::SCALE_W
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             en,
    input  logic             in_valid,
    input  logic             in_tag,
    input  logic [NUM_W-1:0] num_x,
    input  logic [NUM_W-1:0] num_y,
    input  logic [DEN_W-1:0] den,
    output logic             out_valid,
    output logic             out_tag,
    output logic [NUM_W-1:0] quot_x,
    output logic [NUM_W-1:0] quot_y
);

    // One restoring step per stage; the dividend shifts out as the quotient shifts in
    logic             valid_reg [NUM_W];
    logic             tag_reg   [NUM_W];
    logic [NUM_W-1:0] nx_reg    [NUM_W];
    logic [NUM_W-1:0] ny_reg    [NUM_W];
    logic [DEN_W-1:0] rx_reg    [NUM_W];
    logic [DEN_W-1:0] ry_reg    [NUM_W];

    for (genvar k = 0; k < NUM_W; k++)
    begin : g_stage
        logic             cur_valid, cur_tag;
        logic [NUM_W-1:0] cur_nx, cur_ny;
        logic [DEN_W-1:0] cur_rx, cur_ry;
        logic [DEN_W:0]   tx, ty;
        logic             gex, gey;

        if (k == 0)
        begin : g_first
            assign cur_valid = in_valid;
            assign cur_tag   = in_tag;
            assign cur_nx    = num_x;
            assign cur_ny    = num_y;
            assign cur_rx    = '0;
            assign cur_ry    = '0;
        end
        else
        begin : g_rest
            assign cur_valid = valid_reg[k-1];
            assign cur_tag   = tag_reg[k-1];
            assign cur_nx    = nx_reg[k-1];
            assign cur_ny    = ny_reg[k-1];
            assign cur_rx    = rx_reg[k-1];
            assign cur_ry    = ry_reg[k-1];
        end

        assign tx  = {cur_rx, cur_nx[NUM_W-1]};
        assign ty  = {cur_ry, cur_ny[NUM_W-1]};
        assign gex = tx >= {1'b0, den};
        assign gey = ty >= {1'b0, den};

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[k] <= 1'b0;
            end
            else if (en)
            begin
                valid_reg[k] <= cur_valid;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                tag_reg[k] <= cur_tag;
                nx_reg[k]  <= {cur_nx[NUM_W-2:0], gex};
                ny_reg[k]  <= {cur_ny[NUM_W-2:0], gey};
                rx_reg[k]  <= gex ? DEN_W'(tx - {1'b0, den}) : tx[DEN_W-1:0];
                ry_reg[k]  <= gey ? DEN_W'(ty - {1'b0, den}) : ty[DEN_W-1:0];
            end
        end
    end

    assign out_valid = valid_reg[NUM_W-1];
    assign out_tag   = tag_reg[NUM_W-1];
    assign quot_x    = nx_reg[NUM_W-1];
    assign quot_y    = ny_reg[NUM_W-1];

endmodule

// ===== rtl/srsm_skid.sv =====
module srsm_skid (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  srsm_pkg::pix_out_t in_data,
    output logic               up_ready,
    srsm_stream_if.source      down
);

    logic               out_valid_reg;
    srsm_pkg::pix_out_t out_data_reg;
    logic               skid_valid_reg;
    srsm_pkg::pix_out_t skid_data_reg;

    logic take_out;

    // Upstream advances until the spare entry is occupied
    assign up_ready = !skid_valid_reg;
    assign take_out = !out_valid_reg || down.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (up_ready)
        begin
            if (take_out)
            begin
                out_valid_reg <= in_valid;
            end
            else
            begin
                skid_valid_reg <= in_valid;
            end
        end
        else if (down.ready)
        begin
            out_valid_reg  <= 1'b1;
            skid_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (up_ready)
        begin
            if (take_out)
            begin
                out_data_reg <= in_data;
            end
            else
            begin
                skid_data_reg <= in_data;
            end
        end
        else if (down.ready)
        begin
            out_data_reg <= skid_data_reg;
        end
    end

    assign down.valid = out_valid_reg;
    assign down.data  = out_data_reg;

endmodule

// ===== rtl/scale_rotate_source_mapper_top.sv =====
// Screen-to-source pixel mapper for a nearest-neighbor scale and rotate blit.
// pixel_req carries one screen coordinate per transfer; pixel_map returns, in
// order, one transfer per request: covered flag, source column, row and index.
// Registers are written on cfg_we with cfg_index selecting: image width,
// image height, rotation, zoom, overlay, horizontal pan, vertical pan.
// After reset and after every register write a setup sequencer computes the
// frame scale (two 9.16 divisions, one quotient bit per cycle) and the
// target placement; pixel_req.ready stays low until that setup completes.
// Throughput is one pixel per cycle while setup is ready and the receiver
// does not stall. A result passes through three front stages, a 30-stage
// restoring divider (one quotient bit per stage, both axes side by side), two
// mapping stages and the output register.
// When the receiver stalls, the result waits in the output register and one
// more item is caught in a skid entry; the pipeline then holds in place and
// pixel_req.ready drops until the output drains. Nothing is dropped or repeated.
module scale_rotate_source_mapper_top (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [srsm_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [srsm_pkg::CFG_DATA_W-1:0]  cfg_data,
    srsm_stream_if.sink                      pixel_req,
    srsm_stream_if.source                    pixel_map
);

    localparam int IMG_W   = srsm_pkg::IMG_W;
    localparam int POS_W   = srsm_pkg::POS_W;
    localparam int TGT_W   = srsm_pkg::TGT_W;
    localparam int NUM_W   = srsm_pkg::NUM_W;
    localparam int FRAC_W  = srsm_pkg::FRAC_W;
    localparam int SRC_W   = srsm_pkg::SRC_W;
    localparam int PRD_W   = SRC_W + IMG_W;

    srsm_pkg::frame_t frame;
    logic             setup_ready;
    logic             en;
    logic             accept;

    srsm_setup u_setup (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .frame     (frame),
        .ready     (setup_ready)
    );

    assign pixel_req.ready = en && setup_ready;
    assign accept          = pixel_req.valid && pixel_req.ready;

    // Stage 1: capture coordinate
    logic                      p1_valid_reg;
    logic [srsm_pkg::COL_W-1:0] p1_col_reg;
    logic [srsm_pkg::ROW_W-1:0] p1_row_reg;

    // Stage 2: viewport check, offsets into target
    logic                    p2_valid_reg, p2_view_reg;
    logic signed [POS_W-1:0] p2_dx_reg, p2_dy_reg;
    logic signed [POS_W-1:0] sx_s, sy_s;
    logic                    view_ok;

    always_comb
    begin
        sx_s    = $signed(POS_W'(p1_col_reg));
        sy_s    = $signed(POS_W'(p1_row_reg));
        view_ok = !frame.bad && (32'(p1_col_reg) < 32'(srsm_pkg::SCREEN_WIDTH)) &&
                  (sy_s >= frame.vy) && (sy_s < frame.vend);
    end

    // Stage 3: target rectangle check
    logic             p3_valid_reg, p3_ok_reg;
    logic [TGT_W-1:0] p3_dx_reg, p3_dy_reg;
    logic             in_tgt;

    always_comb
    begin
        in_tgt = p2_view_reg &&
                 (p2_dx_reg >= 0) && (p2_dx_reg < $signed(POS_W'(frame.tw))) &&
                 (p2_dy_reg >= 0) && (p2_dy_reg < $signed(POS_W'(frame.th)));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p1_valid_reg <= 1'b0;
            p2_valid_reg <= 1'b0;
            p3_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            p1_valid_reg <= accept;
            p2_valid_reg <= p1_valid_reg;
            p3_valid_reg <= p2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p1_col_reg  <= pixel_req.data.screen_col;
            p1_row_reg  <= pixel_req.data.screen_row;
            p2_view_reg <= view_ok;
            p2_dx_reg   <= sx_s - frame.left;
            p2_dy_reg   <= sy_s - frame.top;
            p3_ok_reg   <= in_tgt;
            p3_dx_reg   <= p2_dx_reg[TGT_W-1:0];
            p3_dy_reg   <= p2_dy_reg[TGT_W-1:0];
        end
    end

    // Divide offsets by the 9.16 scale
    logic             dv_valid, dv_ok;
    logic [NUM_W-1:0] qx, qy;

    srsm_div_pipe #(
        .NUM_W (NUM_W),
        .DEN_W (srsm_pkg::SCALE_W)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (p3_valid_reg),
        .in_tag    (p3_ok_reg),
        .num_x     ({p3_dx_reg, FRAC_W'(0)}),
        .num_y     ({p3_dy_reg, FRAC_W'(0)}),
        .den       (frame.scale),
        .out_valid (dv_valid),
        .out_tag   (dv_ok),
        .quot_x    (qx),
        .quot_y    (qy)
    );

    // Stage 4: range check and rotation back to source axes
    logic             p4_valid_reg, p4_cov_reg;
    logic [SRC_W-1:0] p4_cx_reg, p4_cy_reg;
    logic             cov;
    logic [IMG_W-1:0] rx, ry, cx, cy;

    always_comb
    begin
        cov = dv_ok && (qx < NUM_W'(frame.rw)) && (qy < NUM_W'(frame.rh));
        rx  = qx[IMG_W-1:0];
        ry  = qy[IMG_W-1:0];
        unique case (frame.rot)
            srsm_pkg::ROT_90:
            begin
                cx = ry;
                cy = frame.h - IMG_W'(1) - rx;
            end
            srsm_pkg::ROT_180:
            begin
                cx = frame.w - IMG_W'(1) - rx;
                cy = frame.h - IMG_W'(1) - ry;
            end
            srsm_pkg::ROT_270:
            begin
                cx = frame.w - IMG_W'(1) - ry;
                cy = rx;
            end
            default:
            begin
                cx = rx;
                cy = ry;
            end
        endcase
    end

    // Stage 5: row times width
    logic             p5_valid_reg, p5_cov_reg;
    logic [SRC_W-1:0] p5_cx_reg, p5_cy_reg;
    logic [PRD_W-1:0] p5_prod_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p4_valid_reg <= 1'b0;
            p5_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            p4_valid_reg <= dv_valid;
            p5_valid_reg <= p4_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p4_cov_reg  <= cov;
            p4_cx_reg   <= cov ? cx[SRC_W-1:0] : '0;
            p4_cy_reg   <= cov ? cy[SRC_W-1:0] : '0;
            p5_cov_reg  <= p4_cov_reg;
            p5_cx_reg   <= p4_cx_reg;
            p5_cy_reg   <= p4_cy_reg;
            p5_prod_reg <= PRD_W'(p4_cy_reg) * PRD_W'(frame.w);
        end
    end

    // Index sum into the output buffer
    srsm_pkg::pix_out_t res;
    logic [PRD_W-1:0]   idx_sum;

    always_comb
    begin
        idx_sum       = p5_prod_reg + PRD_W'(p5_cx_reg);
        res.covered   = p5_cov_reg;
        res.src_col   = p5_cx_reg;
        res.src_row   = p5_cy_reg;
        res.src_index = idx_sum[srsm_pkg::INDEX_W-1:0];
    end

    srsm_skid u_skid (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (p5_valid_reg),
        .in_data  (res),
        .up_ready (en),
        .down     (pixel_map)
    );

endmodule

// ===== test/tb_scale_rotate_source_mapper_top.sv =====
module tb_scale_rotate_source_mapper_top;
    import srsm_pkg::*;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    srsm_stream_if #(.data_t(pix_in_t))  pixel_req ();
    srsm_stream_if #(.data_t(pix_out_t)) pixel_map ();

    scale_rotate_source_mapper_top i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .pixel_req (pixel_req.sink),
        .pixel_map (pixel_map.source)
    );

    // Shadow copy of the register file
    logic [IMG_W-1:0]        shadow_w;
    logic [IMG_W-1:0]        shadow_h;
    rot_t                    shadow_rot;
    zoom_t                   shadow_zoom;
    logic                    shadow_overlay;
    logic signed [PAN_W-1:0] shadow_pan_h;
    logic signed [PAN_W-1:0] shadow_pan_v;

    pix_in_t  pixel_backlog[$];
    pix_out_t pending_maps[$];
    int       error_count;
    int       burst_left;
    int       gap_left;
    int       stall_mode;
    int       stall_timer;

    // Clock
    initial clk = 1'b0;
    always #5 clk = ~clk;

    function automatic longint limit_pan(longint v, longint lim);
        if (v < -lim) return -lim;
        if (v > lim) return lim;
        return v;
    endfunction

    // Expected mapping of one screen pixel under the shadow registers
    function automatic pix_out_t map_pixel(pix_in_t px);
        pix_out_t o;
        longint sx, sy, w, h, vy, vh, rw, rh, tw, th, mx, my, left, top, rx, ry, cx, cy;
        longint unsigned scale, hs, vs;
        logic turned;
        o  = '0;
        sx = px.screen_col;
        sy = px.screen_row;
        w  = shadow_w;
        h  = shadow_h;
        vy = shadow_overlay ? VIEW_TOP : 0;
        vh = shadow_overlay ? VIEW_HEIGHT : SCREEN_HEIGHT;
        turned = (shadow_rot == ROT_90) || (shadow_rot == ROT_270);
        if (w < 1 || h < 1 || w > MAX_SIDE || h > MAX_SIDE) return o;
        if (sx >= SCREEN_WIDTH || sy < vy || sy >= vy + vh) return o;
        rw = turned ? h : w;
        rh = turned ? w : h;
        case (shadow_zoom)
            ZOOM_100: scale = 65536;
            ZOOM_150: scale = 98304;
            ZOOM_200: scale = 131072;
            default:
            begin
                hs = (longint'(SCREEN_WIDTH) << 16) / rw;
                vs = (vh << 16) / rh;
                scale = (hs < vs) ? hs : vs;
            end
        endcase
        if (scale == 0) scale = 1;
        tw = (rw * scale + 65535) >> 16;
        th = (rh * scale + 65535) >> 16;
        if (tw < 1) tw = 1;
        if (th < 1) th = 1;
        mx = (tw > SCREEN_WIDTH) ? (tw - SCREEN_WIDTH) / 2 : 0;
        my = (th > vh) ? (th - vh) / 2 : 0;
        left = (SCREEN_WIDTH - tw) / 2 - limit_pan(longint'(shadow_pan_h), mx);
        top  = vy + (vh - th) / 2 - limit_pan(longint'(shadow_pan_v), my);
        if (sy < top || sy >= top + th) return o;
        if (sx < left || sx >= left + tw) return o;
        ry = ((sy - top) << 16) / longint'(scale);
        rx = ((sx - left) << 16) / longint'(scale);
        if (ry >= rh || rx >= rw) return o;
        case (shadow_rot)
            ROT_90:
            begin
                cx = ry;
                cy = h - 1 - rx;
            end
            ROT_180:
            begin
                cx = w - 1 - rx;
                cy = h - 1 - ry;
            end
            ROT_270:
            begin
                cx = w - 1 - ry;
                cy = rx;
            end
            default:
            begin
                cx = rx;
                cy = ry;
            end
        endcase
        o.covered   = 1'b1;
        o.src_col   = cx[SRC_W-1:0];
        o.src_row   = cy[SRC_W-1:0];
        o.src_index = INDEX_W'(cy * w + cx);
        return o;
    endfunction

    // Request driver: bursts with random gaps
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pixel_req.valid <= 1'b0;
            pixel_req.data  <= '0;
            burst_left      <= 0;
            gap_left        <= 0;
        end
        else if (!pixel_req.valid || pixel_req.ready)
        begin
            if (pixel_req.valid)
                pending_maps.push_back(map_pixel(pixel_req.data));
            if (gap_left > 0)
            begin
                gap_left        <= gap_left - 1;
                pixel_req.valid <= 1'b0;
            end
            else if (pixel_backlog.size() > 0)
            begin
                pixel_req.valid <= 1'b1;
                pixel_req.data  <= pixel_backlog.pop_front();
                if (burst_left <= 1)
                begin
                    burst_left <= $urandom_range(1, 24);
                    gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                end
                else
                    burst_left <= burst_left - 1;
            end
            else
                pixel_req.valid <= 1'b0;
        end
    end

    // Result monitor and receiver stall pattern
    always @(posedge clk or negedge rst_n)
    begin
        pix_out_t exp_map;
        if (!rst_n)
        begin
            pixel_map.ready <= 1'b0;
            stall_mode      <= 0;
            stall_timer     <= 0;
        end
        else
        begin
            if (pixel_map.valid && pixel_map.ready)
            begin
                if (pending_maps.size() == 0)
                begin
                    $error("unexpected transfer on pixel_map");
                    error_count++;
                end
                else
                begin
                    exp_map = pending_maps.pop_front();
                    if (pixel_map.data.covered !== exp_map.covered)
                    begin
                        $error("covered expected %0d got %0d",
                               exp_map.covered, pixel_map.data.covered);
                        error_count++;
                    end
                    if (pixel_map.data.src_col !== exp_map.src_col)
                    begin
                        $error("src_col expected %0d got %0d",
                               exp_map.src_col, pixel_map.data.src_col);
                        error_count++;
                    end
                    if (pixel_map.data.src_row !== exp_map.src_row)
                    begin
                        $error("src_row expected %0d got %0d",
                               exp_map.src_row, pixel_map.data.src_row);
                        error_count++;
                    end
                    if (pixel_map.data.src_index !== exp_map.src_index)
                    begin
                        $error("src_index expected %0d got %0d",
                               exp_map.src_index, pixel_map.data.src_index);
                        error_count++;
                    end
                end
            end
            if (stall_timer == 0)
            begin
                stall_mode  <= $urandom_range(0, 2);
                stall_timer <= $urandom_range(16, 96);
            end
            else
                stall_timer <= stall_timer - 1;
            case (stall_mode)
                0:       pixel_map.ready <= 1'b1;
                1:       pixel_map.ready <= $urandom_range(0, 1);
                default: pixel_map.ready <= ($urandom_range(0, 5) == 0);
            endcase
        end
    end

    // Register write, block must be idle
    task automatic write_reg(cfg_index_t idx, logic [CFG_DATA_W-1:0] value);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        case (idx)
            CFG_IMAGE_WIDTH:    shadow_w       = value[IMG_W-1:0];
            CFG_IMAGE_HEIGHT:   shadow_h       = value[IMG_W-1:0];
            CFG_ROTATION_STEP:  shadow_rot     = rot_t'(value[ROT_W-1:0]);
            CFG_ZOOM_SELECT:    shadow_zoom    = zoom_t'(value[ZOOM_W-1:0]);
            CFG_OVERLAY_SHOWN:  shadow_overlay = value[0];
            CFG_PAN_HORIZONTAL: shadow_pan_h   = value;
            default:            shadow_pan_v   = value;
        endcase
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic set_frame(int w, int h, rot_t rot, zoom_t zoom, bit ovl, int ph, int pv);
        write_reg(CFG_IMAGE_WIDTH, CFG_DATA_W'(w));
        write_reg(CFG_IMAGE_HEIGHT, CFG_DATA_W'(h));
        write_reg(CFG_ROTATION_STEP, CFG_DATA_W'(rot));
        write_reg(CFG_ZOOM_SELECT, CFG_DATA_W'(zoom));
        write_reg(CFG_OVERLAY_SHOWN, CFG_DATA_W'(ovl));
        write_reg(CFG_PAN_HORIZONTAL, CFG_DATA_W'(ph));
        write_reg(CFG_PAN_VERTICAL, CFG_DATA_W'(pv));
    endtask

    task automatic drain();
        while (pixel_backlog.size() > 0 || pixel_req.valid || pending_maps.size() > 0)
            @(posedge clk);
    endtask

    task automatic push_pixel(int col, int row);
        pix_in_t px;
        px.screen_col = COL_W'(col);
        px.screen_row = ROW_W'(row);
        pixel_backlog.push_back(px);
    endtask

    // Mostly on-screen pixels, some beyond the screen edge
    task automatic push_random(int n);
        for (int i = 0; i < n; i++)
        begin
            if ($urandom_range(0, 7) == 0)
                push_pixel($urandom_range(0, 511), $urandom_range(0, 255));
            else
                push_pixel($urandom_range(0, SCREEN_WIDTH - 1), $urandom_range(0, 239));
        end
    endtask

    function automatic int rand_side();
        case ($urandom_range(0, 15))
            0:       return MAX_SIDE;
            1:       return 1;
            2:       return ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(MAX_SIDE + 1, 8191);
            3, 4:    return $urandom_range(1, MAX_SIDE);
            default: return $urandom_range(1, 400);
        endcase
    endfunction

    function automatic int rand_pan();
        if ($urandom_range(0, 3) == 0)
            return $urandom_range(0, 16383);
        return $urandom_range(0, 600) - 300;
    endfunction

    // Stimulus
    initial
    begin
        error_count = 0;
        rst_n       = 1'b0;
        cfg_we      = 1'b0;
        cfg_index   = '0;
        cfg_data    = '0;
        shadow_w       = 1;
        shadow_h       = 1;
        shadow_rot     = ROT_0;
        shadow_zoom    = ZOOM_FIT;
        shadow_overlay = 1'b1;
        shadow_pan_h   = '0;
        shadow_pan_v   = '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // Reset settings: viewport edges, screen edges, out of range coordinates
        push_pixel(0, 0);
        push_pixel(0, VIEW_TOP - 1);
        push_pixel(0, VIEW_TOP);
        push_pixel(SCREEN_WIDTH - 1, VIEW_TOP + VIEW_HEIGHT - 1);
        push_pixel(0, VIEW_TOP + VIEW_HEIGHT);
        push_pixel(SCREEN_WIDTH, 100);
        push_pixel(511, 255);
        push_pixel(160, 115);
        push_pixel(159, 116);
        drain();

        // Whole screen, odd centering, large image, extreme pans, invalid sizes
        set_frame(333, 77, ROT_0, ZOOM_150, 1'b0, 8191, -8192);
        push_pixel(0, 0);
        push_pixel(SCREEN_WIDTH - 1, 239);
        push_pixel(160, 120);
        push_pixel(5, 200);
        drain();
        set_frame(MAX_SIDE, MAX_SIDE, ROT_90, ZOOM_200, 1'b1, -8192, 8191);
        push_pixel(0, VIEW_TOP);
        push_pixel(SCREEN_WIDTH - 1, VIEW_TOP + VIEW_HEIGHT - 1);
        push_pixel(100, 100);
        drain();
        set_frame(MAX_SIDE, 1, ROT_270, ZOOM_FIT, 1'b0, 0, 0);
        push_random(4);
        drain();
        set_frame(0, 50, ROT_180, ZOOM_100, 1'b1, 0, 0);
        push_pixel(160, 100);
        drain();
        set_frame(50, 8191, ROT_0, ZOOM_100, 1'b1, 0, 0);
        push_pixel(160, 100);
        drain();

        // Random frames, one pause mid stream until all results return
        for (int p = 0; p < 24; p++)
        begin
            set_frame(rand_side(), rand_side(), rot_t'($urandom_range(0, 3)),
                      zoom_t'($urandom_range(0, 3)), $urandom_range(0, 1),
                      rand_pan(), rand_pan());
            push_random(20);
            if (p == 3)
                drain();
            push_random(20);
            drain();
        end

        repeat (50) @(posedge clk);
        if (error_count == 0)
            $display("tb_scale_rotate_source_mapper_top: done, clean");
        else
            $display("tb_scale_rotate_source_mapper_top: done, errors");
        $finish;
    end

    // Watchdog
    initial
    begin
        #20000000;
        $display("tb_scale_rotate_source_mapper_top: done, errors");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/srsm_pkg.sv
rtl/srsm_stream_if.sv
rtl/srsm_setup.sv
rtl/srsm_div_pipe.sv
rtl/srsm_skid.sv
rtl/scale_rotate_source_mapper_top.sv
test/tb_scale_rotate_source_mapper_top.sv
